// File: design/trmb_pkg.sv
// Shared types, constants and rounding helpers for the textured rectangle blender.
package trmb_pkg;

  // Defaults for the top level parameters
  localparam int TEX_MAX_DIM_DEF = 128;
  localparam int FRAC_BITS_DEF   = 24;

  // Input item kinds
  localparam logic OP_TEXEL_WRITE = 1'b0;
  localparam logic OP_SHADE       = 1'b1;

  localparam logic [7:0]  CHAN_MAX   = 8'hFF;
  localparam logic [31:0] WHITE_ARGB = 32'hFFFF_FFFF;
  localparam logic [31:0] FILL_RESET = 32'hFFFF_FFFF;
  localparam logic [15:0] ROUND_HALF = 16'd127;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_U_START    = 3'd0,
    REG_U_STEP     = 3'd1,
    REG_V_START    = 3'd2,
    REG_V_STEP     = 3'd3,
    REG_FILL_COLOR = 3'd4,
    REG_TEX_WIDTH  = 3'd5,
    REG_TEX_HEIGHT = 3'd6
  } cfg_reg_e;

  // Mapping registers seen by the coordinate pipe
  typedef struct packed {
    logic [31:0] u_start;
    logic [31:0] u_step;
    logic [31:0] v_start;
    logic [31:0] v_step;
    logic [7:0]  tex_width;
    logic [7:0]  tex_height;
  } trmb_cfg_t;

  // Per-word control plus payload once the store address is known
  typedef struct packed {
    logic        op;      // item kind
    logic        white;   // no texture loaded, sample reads as white
    logic        wr_en;   // texel write hits the store
    logic [31:0] word;    // texel data for writes, destination pixel for shades
  } trmb_item_t;

  // floor((x + 127) / 255) for x up to 255*255
  function automatic logic [7:0] rdiv255(input logic [15:0] x);
    logic [16:0] y;
    logic [16:0] s;
    y = 17'(x) + 17'(ROUND_HALF);
    s = y + 17'(y[16:8]) + 17'd1;
    return s[15:8];
  endfunction

  // Channel product with rounding to /255
  function automatic logic [7:0] mod255(input logic [7:0] t, input logic [7:0] c);
    return rdiv255(16'(t) * 16'(c));
  endfunction

endpackage

// File: design/textured_rect_modulate_blend.sv
// One word per cycle sustained while out_ready_i stays high.
// Four coordinate stages feed one texture store port (read or write per cycle),
// then two shading stages; each stage holds its word under back pressure.
// Reset clears all stage valid bits and the configuration registers
// (fill color to opaque white, all others to zero); store contents stay undefined.
module textured_rect_modulate_blend import trmb_pkg::*; #(
  parameter int TEX_MAX_DIM = TEX_MAX_DIM_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [13:0] texel_addr_i,
  input  logic [31:0] texel_data_i,
  input  logic [11:0] col_offset_i,
  input  logic [11:0] row_offset_i,
  input  logic [31:0] dest_pixel_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_pixel_o,
  output logic        write_enable_o
);

  localparam int ADDR_W = (TEX_MAX_DIM > 1) ? $clog2(TEX_MAX_DIM * TEX_MAX_DIM) : 1;

  // Configuration registers
  trmb_cfg_t   cfg_q;
  logic [31:0] fill_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= '0;
      fill_q <= FILL_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_U_START:    cfg_q.u_start    <= cfg_data_i;
        REG_U_STEP:     cfg_q.u_step     <= cfg_data_i;
        REG_V_START:    cfg_q.v_start    <= cfg_data_i;
        REG_V_STEP:     cfg_q.v_step     <= cfg_data_i;
        REG_FILL_COLOR: fill_q           <= cfg_data_i;
        REG_TEX_WIDTH:  cfg_q.tex_width  <= cfg_data_i[7:0];
        REG_TEX_HEIGHT: cfg_q.tex_height <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Coordinate pipe
  logic              c_valid, c_ready;
  trmb_item_t        c_item;
  logic [ADDR_W-1:0] c_addr;

  trmb_coord #(
    .TEX_MAX_DIM (TEX_MAX_DIM),
    .FRAC_BITS   (FRAC_BITS)
  ) u_coord (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .texel_addr_i (texel_addr_i),
    .texel_data_i (texel_data_i),
    .col_offset_i (col_offset_i),
    .row_offset_i (row_offset_i),
    .dest_pixel_i (dest_pixel_i),
    .out_valid_o  (c_valid),
    .out_ready_i  (c_ready),
    .out_item_o   (c_item),
    .out_addr_o   (c_addr)
  );

  // Stage 5: store access, writes and reads kept in word order
  logic       v5_q, en5, s_ready;
  trmb_item_t item5_q;
  logic [31:0] texel;

  assign en5     = !v5_q || s_ready;
  assign c_ready = en5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en5) begin
      v5_q <= c_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) item5_q <= c_item;
  end

  trmb_ram #(
    .TEX_MAX_DIM (TEX_MAX_DIM)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (en5 && c_valid),
    .we_i    (c_item.wr_en),
    .addr_i  (c_addr),
    .wdata_i (c_item.word),
    .rdata_o (texel)
  );

  // Shading pipe
  trmb_shade u_shade (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fill_color_i   (fill_q),
    .in_valid_i     (v5_q),
    .in_ready_o     (s_ready),
    .in_item_i      (item5_q),
    .texel_i        (texel),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_pixel_o    (out_pixel_o),
    .write_enable_o (write_enable_o)
  );

endmodule

// File: design/trmb_coord.sv
// Coordinate pipe: texture coordinates, nearest index, clamp and store address.
module trmb_coord import trmb_pkg::*; #(
  parameter int TEX_MAX_DIM = TEX_MAX_DIM_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int ADDR_W     = (TEX_MAX_DIM > 1) ? $clog2(TEX_MAX_DIM * TEX_MAX_DIM) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  trmb_cfg_t         cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic [13:0]       texel_addr_i,
  input  logic [31:0]       texel_data_i,
  input  logic [11:0]       col_offset_i,
  input  logic [11:0]       row_offset_i,
  input  logic [31:0]       dest_pixel_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output trmb_item_t        out_item_o,
  output logic [ADDR_W-1:0] out_addr_o
);

  localparam int DIM_W  = $clog2(TEX_MAX_DIM + 1);
  localparam int IDX_W  = (TEX_MAX_DIM > 1) ? $clog2(TEX_MAX_DIM) : 1;
  localparam int CMP_W  = (DIM_W > 8) ? DIM_W : 8;
  localparam int C2_W   = 47;
  localparam int P_W    = C2_W + DIM_W + 1;
  localparam int LIN_W  = ADDR_W + DIM_W;
  localparam int TA_W   = (ADDR_W + 1 > 14) ? ADDR_W + 1 : 14;
  localparam logic [CMP_W-1:0] DIM_MAX   = CMP_W'(TEX_MAX_DIM);
  localparam logic [TA_W-1:0]  DEPTH_CMP = TA_W'(TEX_MAX_DIM * TEX_MAX_DIM);

  // Clamped texture size
  logic [DIM_W-1:0] tw, th;
  logic             white;
  always_comb begin
    tw = (CMP_W'(cfg_i.tex_width) > DIM_MAX) ? DIM_W'(TEX_MAX_DIM)
                                              : DIM_W'(cfg_i.tex_width);
    th = (CMP_W'(cfg_i.tex_height) > DIM_MAX) ? DIM_W'(TEX_MAX_DIM)
                                               : DIM_W'(cfg_i.tex_height);
    white = (tw == '0) || (th == '0);
  end

  // Stage handshake: a stage loads when empty or when its word moves on
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Stage 1: doubled coordinate 2*start + (2*off+1)*step
  function automatic logic signed [C2_W-1:0] coord2(input logic [31:0] start,
                                                    input logic [31:0] step,
                                                    input logic [11:0] off);
    logic signed [C2_W-1:0] s2;
    logic signed [C2_W-1:0] prod;
    s2   = C2_W'($signed({start, 1'b0}));
    prod = C2_W'($signed({1'b0, off, 1'b1})) * C2_W'($signed(step));
    return s2 + prod;
  endfunction

  logic signed [C2_W-1:0] cu_q, cv_q;
  logic                   op1_q, op2_q, op3_q;
  logic [31:0]            word1_q, word2_q, word3_q;
  logic [13:0]            ta1_q, ta2_q, ta3_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      cu_q    <= coord2(cfg_i.u_start, cfg_i.u_step, col_offset_i);
      cv_q    <= coord2(cfg_i.v_start, cfg_i.v_step, row_offset_i);
      op1_q   <= op_i;
      word1_q <= (op_i == OP_TEXEL_WRITE) ? texel_data_i : dest_pixel_i;
      ta1_q   <= texel_addr_i;
    end
  end

  // Stage 2: scale by texture size
  logic signed [P_W-1:0] pu_q, pv_q;
  always_ff @(posedge clk_i) begin
    if (en2) begin
      pu_q    <= P_W'(cu_q) * P_W'($signed({1'b0, tw}));
      pv_q    <= P_W'(cv_q) * P_W'($signed({1'b0, th}));
      op2_q   <= op1_q;
      word2_q <= word1_q;
      ta2_q   <= ta1_q;
    end
  end

  // Stage 3: drop fraction and clamp to 0..dim-1
  function automatic logic [IDX_W-1:0] near_idx(input logic signed [P_W-1:0] p,
                                                input logic [DIM_W-1:0] dim);
    logic [P_W-1:0] sh;
    sh = P_W'(p >>> (FRAC_BITS + 1));
    if (p[P_W-1])
      return '0;
    else if (sh >= P_W'(dim))
      return IDX_W'(dim - 1'b1);
    else
      return sh[IDX_W-1:0];
  endfunction

  logic [IDX_W-1:0] sx_q, sy_q;
  always_ff @(posedge clk_i) begin
    if (en3) begin
      sx_q    <= near_idx(pu_q, tw);
      sy_q    <= near_idx(pv_q, th);
      op3_q   <= op2_q;
      word3_q <= word2_q;
      ta3_q   <= ta2_q;
    end
  end

  // Stage 4: linear store address, or the write address for texel loads
  logic [LIN_W-1:0] lin;
  logic             ta_hit;
  assign lin    = LIN_W'(sy_q) * LIN_W'(tw) + LIN_W'(sx_q);
  assign ta_hit = TA_W'(ta3_q) < DEPTH_CMP;

  trmb_item_t        item4_q;
  logic [ADDR_W-1:0] addr4_q;
  always_ff @(posedge clk_i) begin
    if (en4) begin
      item4_q.op    <= op3_q;
      item4_q.white <= white;
      item4_q.wr_en <= (op3_q == OP_TEXEL_WRITE) && ta_hit;
      item4_q.word  <= word3_q;
      addr4_q       <= (op3_q == OP_TEXEL_WRITE) ? ADDR_W'(ta3_q) : lin[ADDR_W-1:0];
    end
  end

  assign out_valid_o = v4_q;
  assign out_item_o  = item4_q;
  assign out_addr_o  = addr4_q;

endmodule

// File: design/trmb_ram.sv
// Single-port texture store with registered read data.
module trmb_ram import trmb_pkg::*; #(
  parameter int TEX_MAX_DIM = TEX_MAX_DIM_DEF,
  localparam int ADDR_W     = (TEX_MAX_DIM > 1) ? $clog2(TEX_MAX_DIM * TEX_MAX_DIM) : 1
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [31:0]       wdata_i,
  output logic [31:0]       rdata_o
);

  localparam int DEPTH = TEX_MAX_DIM * TEX_MAX_DIM;

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  // One access per cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) mem[addr_i] <= wdata_i;
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/trmb_shade.sv
// Shading pipe: color modulation, then straight alpha blend over the destination.
module trmb_shade import trmb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] fill_color_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  trmb_item_t  in_item_i,
  input  logic [31:0] texel_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_pixel_o,
  output logic        write_enable_o
);

  logic v6_q, v7_q;
  logic en6, en7;
  assign en7 = !v7_q || out_ready_i;
  assign en6 = !v6_q || en7;
  assign in_ready_o = en6;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (en6) v6_q <= in_valid_i;
      if (en7) v7_q <= v6_q;
    end
  end

  // Stage 6: modulate texel by fill color
  logic [31:0] tex;
  assign tex = in_item_i.white ? WHITE_ARGB : texel_i;

  logic [7:0]  ma_q, mr_q, mg_q, mb_q;
  logic        op6_q;
  logic [31:0] dst_q;
  always_ff @(posedge clk_i) begin
    if (en6) begin
      ma_q  <= mod255(tex[31:24], fill_color_i[31:24]);
      mr_q  <= mod255(tex[23:16], fill_color_i[23:16]);
      mg_q  <= mod255(tex[15:8],  fill_color_i[15:8]);
      mb_q  <= mod255(tex[7:0],   fill_color_i[7:0]);
      op6_q <= in_item_i.op;
      dst_q <= in_item_i.word;
    end
  end

  // Stage 7: blend, alpha forced opaque; skip writes and zero alpha
  function automatic logic [7:0] blend(input logic [7:0] m, input logic [7:0] a,
                                       input logic [7:0] d);
    logic [15:0] sum;
    sum = 16'(m) * 16'(a) + 16'(d) * 16'(CHAN_MAX - a);
    return rdiv255(sum);
  endfunction

  logic        keep;
  logic [31:0] pix_q;
  logic        we_q;
  assign keep = (op6_q == OP_SHADE) && (ma_q != '0);

  always_ff @(posedge clk_i) begin
    if (en7) begin
      we_q  <= keep;
      pix_q <= keep ? {CHAN_MAX,
                       blend(mr_q, ma_q, dst_q[23:16]),
                       blend(mg_q, ma_q, dst_q[15:8]),
                       blend(mb_q, ma_q, dst_q[7:0])} : '0;
    end
  end

  assign out_valid_o    = v7_q;
  assign out_pixel_o    = pix_q;
  assign write_enable_o = we_q;

endmodule
